>>> design/srp_pkg.sv
// Package: shared constants, register codes and types of the stream pattern replacer.
`default_nettype none
package srp_pkg;

   // Byte and register geometry
   localparam int BYTE_W      = 8;
   localparam int CFG_W       = 64;
   localparam int LEN_W       = 4;
   localparam int RUN_DEPTH   = 8;
   localparam int CNT_W       = 4;
   localparam int IDX_W       = $clog2(RUN_DEPTH);
   localparam int ADDR_W      = 5;
   localparam int DEF_MAX_PATTERN = 8;

   // Register indexes, taken from the word address
   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } reg_index_type;

   // One run of results caused by a single input word
   typedef struct packed {
      logic [RUN_DEPTH-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                 count;
      logic                             eol;
   } run_type;

endpackage
`default_nettype wire

>>> design/srp_req_if.sv
// Interface: input channel carrying one text byte and its end-of-line flag.
`default_nettype none
interface srp_req_if
   import srp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_line;

   modport source (output valid, output in_byte, output end_of_line, input ready);
   modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface
`default_nettype wire

>>> design/srp_rsp_if.sv
// Interface: result channel carrying one rewritten byte and its flags.
`default_nettype none
interface srp_rsp_if
   import srp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic              line_end;
   logic              last_of_run;

   modport source (output valid, output out_byte, output byte_valid, output line_end,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input line_end,
                   input last_of_run, output ready);
endinterface
`default_nettype wire

>>> design/srp_match.sv
// Match engine: held prefix state, full-match check and prefix fallback per word.
`default_nettype none
module srp_match
   import srp_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                clear,
   input  wire logic [BYTE_W-1:0]   in_byte,
   input  wire logic                end_of_line,
   input  wire logic [CFG_W-1:0]    pattern_bytes,
   input  wire logic [LEN_W-1:0]    pattern_length,
   input  wire logic [CFG_W-1:0]    replacement_bytes,
   input  wire logic [LEN_W-1:0]    replacement_length,
   output run_type                  run
);

   localparam int HCW = $clog2(MAX_PATTERN + 1);

   logic [MAX_PATTERN-1:0][BYTE_W-1:0] held_ff, held_in;
   logic [HCW-1:0]                     hcnt_ff, hcnt_in;

   logic [CNT_W-1:0]                   len;
   logic [CNT_W-1:0]                   rlen;
   logic [CNT_W-1:0]                   h;
   logic [CNT_W-1:0]                   n;
   logic [CNT_W-1:0]                   k;
   logic [BYTE_W-1:0]                  last_pat;
   logic                               full_match;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] buf_b;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0] win;
   logic [MAX_PATTERN-1:0]             cand;

   // Clamp the configured lengths
   always_comb begin
      len = pattern_length;
      if (len == '0) begin
         len = CNT_W'(1);
      end else if (len > CNT_W'(MAX_PATTERN)) begin
         len = CNT_W'(MAX_PATTERN);
      end
      rlen = replacement_length;
      if (rlen > CNT_W'(RUN_DEPTH)) begin
         rlen = CNT_W'(RUN_DEPTH);
      end
   end

   // Line up held bytes, new byte and the pattern
   always_comb begin
      h = CNT_W'(hcnt_ff);
      if (h >= len) begin
         h = '0;
      end
      n = h + CNT_W'(1);
      last_pat = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pat[j] = pattern_bytes[j*BYTE_W +: BYTE_W];
         if (j == int'(len) - 1) begin
            last_pat = pat[j];
         end
         buf_b[j] = (j < int'(h)) ? held_ff[j] : in_byte;
      end
      // window counted back from the new byte
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win[i] = in_byte;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (i > 0 && (i + j) == int'(h)) begin
               win[i] = held_ff[j];
            end
         end
      end
      full_match = (n == len) && (in_byte == last_pat);
   end

   // Test every suffix length shorter than the pattern and keep the longest that is a pattern prefix
   always_comb begin
      cand = '0;
      k = '0;
      for (int kk = 1; kk < MAX_PATTERN; kk++) begin
         cand[kk] = (kk <= int'(n)) && (kk < int'(len));
         for (int j = 0; j < kk; j++) begin
            if (win[kk-1-j] != pat[j]) begin
               cand[kk] = 1'b0;
            end
         end
         if (cand[kk]) begin
            k = CNT_W'(kk);
         end
      end
   end

   // Build the run and the next held prefix
   always_comb begin
      held_in = held_ff;
      hcnt_in = hcnt_ff;
      run.eol = end_of_line;
      run.bytes = '0;
      run.count = '0;
      if (full_match) begin
         for (int i = 0; i < RUN_DEPTH; i++) begin
            run.bytes[i] = replacement_bytes[i*BYTE_W +: BYTE_W];
         end
         run.count = rlen;
         hcnt_in = '0;
      end else begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            run.bytes[i] = buf_b[i];
         end
         if (end_of_line) begin
            run.count = n;
            hcnt_in = '0;
         end else begin
            run.count = n - k;
            hcnt_in = HCW'(k);
            for (int kk = 1; kk < MAX_PATTERN; kk++) begin
               if (int'(k) == kk) begin
                  for (int i = 0; i < kk; i++) begin
                     held_in[i] = win[kk-1-i];
                  end
               end
            end
         end
      end
   end

   // Held bytes carry no reset
   always_ff @(posedge clock) begin
      if (step) begin
         held_ff <= held_in;
      end
   end

   // Held count: cleared by reset and by a pattern write
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hcnt_ff <= '0;
      end else if (step) begin
         hcnt_ff <= hcnt_in;
      end
   end

endmodule
`default_nettype wire

>>> design/srp_serializer.sv
// Serializer: holds one run and sends it out one word per cycle while the result channel is ready.
`default_nettype none
module srp_serializer
   import srp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire run_type run,
   output logic         free,
   srp_rsp_if.source    rsp
);

   run_type          run_ff, run_in;
   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             bare;
   logic             last;

   // Decode the word at the current position
   always_comb begin
      bare = (run_ff.count == '0);
      last = bare || ((CNT_W'(idx_ff) + CNT_W'(1)) == run_ff.count);
      free = !valid_ff || (rsp.ready && last);
      rsp.valid       = valid_ff;
      rsp.out_byte    = bare ? '0 : run_ff.bytes[idx_ff];
      rsp.byte_valid  = !bare;
      rsp.last_of_run = last;
      rsp.line_end    = last && run_ff.eol;
   end

   // Load a new run, advance, or drop the finished one
   always_comb begin
      run_in   = run_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         run_in   = run;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && rsp.ready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
`default_nettype wire

>>> design/stream_pattern_replace_top.sv
// Top level: register port, match engine and result serializer of the pattern replacer.
// The first result of a word, if it yields any, appears in the cycle after the word is accepted.
// A word that yields r results (r up to 8) holds the run register until its last result is
// sent, so words whose runs have at most one result are taken every cycle while the result
// channel is ready. The run register and its one-word-per-cycle drain set that rate.
// Reset clears the registers to their reset values, the held count and the run valid flag.
`default_nettype none
module stream_pattern_replace_top
   import srp_pkg::*;
#(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  wire logic              clock,
   input  wire logic              reset,
   srp_req_if.sink                req_chan,
   srp_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [CFG_W-1:0]  csr_pwdata,
   output logic      [CFG_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [CFG_W-1:0] pat_bytes_ff, pat_bytes_in;
   logic [LEN_W-1:0] pat_len_ff, pat_len_in;
   logic [CFG_W-1:0] rep_bytes_ff, rep_bytes_in;
   logic [LEN_W-1:0] rep_len_ff, rep_len_in;
   reg_index_type    reg_sel;
   logic             wr_en;
   logic             clear;
   logic             free;
   logic             step;
   logic             load;
   run_type          run;

   // Register port decode
   always_comb begin
      csr_pready = 1'b1;
      reg_sel = reg_index_type'(csr_paddr[ADDR_W-1:3]);
      wr_en = csr_psel && csr_penable && csr_pwrite;
      pat_bytes_in = pat_bytes_ff;
      pat_len_in   = pat_len_ff;
      rep_bytes_in = rep_bytes_ff;
      rep_len_in   = rep_len_ff;
      clear = 1'b0;
      csr_prdata = '0;
      unique case (reg_sel)
         REG_PATTERN_BYTES: begin
            csr_prdata = pat_bytes_ff;
            if (wr_en) begin
               pat_bytes_in = csr_pwdata;
               clear = 1'b1;
            end
         end
         REG_PATTERN_LENGTH: begin
            csr_prdata = {{(CFG_W-LEN_W){1'b0}}, pat_len_ff};
            if (wr_en) begin
               pat_len_in = csr_pwdata[LEN_W-1:0];
               clear = 1'b1;
            end
         end
         REG_REPLACEMENT_BYTES: begin
            csr_prdata = rep_bytes_ff;
            if (wr_en) begin
               rep_bytes_in = csr_pwdata;
            end
         end
         REG_REPLACEMENT_LENGTH: begin
            csr_prdata = {{(CFG_W-LEN_W){1'b0}}, rep_len_ff};
            if (wr_en) begin
               rep_len_in = csr_pwdata[LEN_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_bytes_ff <= '0;
         pat_len_ff   <= LEN_W'(1);
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
      end else begin
         pat_bytes_ff <= pat_bytes_in;
         pat_len_ff   <= pat_len_in;
         rep_bytes_ff <= rep_bytes_in;
         rep_len_ff   <= rep_len_in;
      end
   end

   // Accept a word whenever the run register is free this cycle
   always_comb begin
      req_chan.ready = free;
      step = req_chan.valid && free;
      load = step && ((run.count != '0) || run.eol);
   end

   srp_match #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_match (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .clear              (clear),
      .in_byte            (req_chan.in_byte),
      .end_of_line        (req_chan.end_of_line),
      .pattern_bytes      (pat_bytes_ff),
      .pattern_length     (pat_len_ff),
      .replacement_bytes  (rep_bytes_ff),
      .replacement_length (rep_len_ff),
      .run                (run)
   );

   srp_serializer u_serializer (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .run   (run),
      .free  (free),
      .rsp   (rsp_chan)
   );

   // A word is taken only while no unfinished run would be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && rsp_chan.valid)
         |-> (rsp_chan.ready && rsp_chan.last_of_run))
      else $error("word accepted over a pending run");

   // A line end closes its run
   a_line_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.line_end) |-> rsp_chan.last_of_run)
      else $error("line end before the last word of a run");

   // A bare marker is a zero line-end word
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.byte_valid)
         |-> (rsp_chan.line_end && rsp_chan.out_byte == '0))
      else $error("bare marker without line end or with data");

   // A run that is not finished stays on the channel
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run) |=> rsp_chan.valid)
      else $error("run dropped before its last word");

endmodule
`default_nettype wire
